/* hdl/cbrs_pkg.sv */
// shared types, constants and stage table for the bring-up retry sequencer
`timescale 1ns / 1ps

package cbrs_pkg;

  localparam int StageW    = 3;
  localparam int TriesW    = 5;
  localparam int CoolW     = 12;
  localparam int IntervalW = 8;
  localparam int LimitW    = 4;
  localparam int ModeW     = 2;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 8;
  localparam int InDataW   = 8;
  localparam int OutDataW  = 32;
  localparam int OutUsedW  = 26;
  localparam int ProdW     = 14;

  localparam logic [3:0] BackoffStep = 4'd10;

  localparam logic [ModeW-1:0]     ResetBackoffMode = 2'd0;
  localparam logic [IntervalW-1:0] ResetInterval    = 8'd10;
  localparam logic [LimitW-1:0]    ResetTriesMain   = 4'd10;
  localparam logic [LimitW-1:0]    ResetTriesLink   = 4'd3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BACKOFF_MODE   = 3'd0,
    CFG_RETRY_INTERVAL = 3'd1,
    CFG_PING_INTERVAL  = 3'd2,
    CFG_MAX_TRIES_MAIN = 3'd3,
    CFG_MAX_TRIES_LINK = 3'd4
  } cfg_idx_t;

  typedef enum logic [ModeW-1:0] {
    BACKOFF_CONST  = 2'd0,
    BACKOFF_LINEAR = 2'd1,
    BACKOFF_QUAD   = 2'd2
  } backoff_t;

  typedef enum logic [1:0] {
    OP_NONE       = 2'd0,
    OP_RELOAD     = 2'd1,
    OP_INVALIDATE = 2'd2
  } opcode_t;

  localparam logic [StageW-1:0] StageNoConfig = 3'd0;
  localparam logic [StageW-1:0] StageSuccess  = 3'd6;

  typedef struct packed {
    logic [ModeW-1:0]     backoff_mode;
    logic [IntervalW-1:0] retry_interval;
    logic [IntervalW-1:0] ping_interval;
    logic [LimitW-1:0]    max_tries_main;
    logic [LimitW-1:0]    max_tries_link;
  } cfg_t;

  typedef struct packed {
    logic [StageW-1:0] stage;
    logic [TriesW-1:0] tries;
    logic [CoolW-1:0]  cooldown;
  } seq_state_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       hold;
    logic       ready_req;
  } in_item_t;

  // packed lowest field last so that tdata bit 0 is stage
  typedef struct packed {
    logic [CoolW-1:0]  cooldown_left;
    logic [TriesW-1:0] try_count;
    logic              ping_invalidate;
    logic [StageW-1:0] attempt_stage;
    logic              attempt;
    logic              stage_set;
    logic [StageW-1:0] stage;
  } out_item_t;

  typedef struct packed {
    logic [StageW-1:0] next;
    logic [StageW-1:0] fail;
    logic              link_limit;
    logic              ping_timing;
  } stage_row_t;

  function automatic stage_row_t stage_row(input logic [StageW-1:0] s);
    stage_row_t r;
    unique case (s)
      3'd0:    r = '{next: 3'd1, fail: 3'd0, link_limit: 1'b0, ping_timing: 1'b0};
      3'd1:    r = '{next: 3'd2, fail: 3'd1, link_limit: 1'b0, ping_timing: 1'b0};
      3'd2:    r = '{next: 3'd3, fail: 3'd1, link_limit: 1'b0, ping_timing: 1'b0};
      3'd3:    r = '{next: 3'd4, fail: 3'd2, link_limit: 1'b1, ping_timing: 1'b0};
      3'd4:    r = '{next: 3'd5, fail: 3'd2, link_limit: 1'b0, ping_timing: 1'b1};
      3'd5:    r = '{next: 3'd6, fail: 3'd3, link_limit: 1'b0, ping_timing: 1'b0};
      3'd6:    r = '{next: 3'd6, fail: 3'd5, link_limit: 1'b0, ping_timing: 1'b1};
      default: r = '{next: 3'd7, fail: 3'd7, link_limit: 1'b0, ping_timing: 1'b0};
    endcase
    return r;
  endfunction

endpackage

/* hdl/connection_bringup_retry_sequencer.sv */
// top level: link bring-up retry sequencer with stream ports and config write channel
`timescale 1ns / 1ps
// path: an accepted item goes through the input register, then the result register
// throughput: one item per cycle unless m_axis_tready stalls; the stage/counter update is one pass of cbrs_step
// reset (rst, synchronous): stage 0, counters zero, pipeline empty, config registers
// back to mode constant, intervals 10, main limit 10, link limit 3

module connection_bringup_retry_sequencer (
  input  logic                               clk,
  input  logic                               rst,
  // input item stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [0] ready_req, [1] hold, [3:2] opcode, [7:4] zero
  input  logic [cbrs_pkg::InDataW-1:0]       s_axis_tdata,
  // result item stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [2:0] stage, [3] stage_set, [4] attempt, [7:5] attempt_stage,
  // [8] ping_invalidate, [13:9] try_count, [25:14] cooldown_left, [31:26] zero
  output logic [cbrs_pkg::OutDataW-1:0]      m_axis_tdata,
  // config write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cbrs_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [cbrs_pkg::CfgDataW-1:0]      cfg_data
);
  import cbrs_pkg::*;

  // config registers
  cfg_t       cfg;

  // sequencer state
  seq_state_t state;
  seq_state_t state_next;

  // input register
  logic       in_valid;
  in_item_t   in_item;

  // result register
  logic       out_valid;
  out_item_t  out_item;
  out_item_t  result;

  logic       advance;

  // the input register item moves on whenever the result slot is free or being drained
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.backoff_mode   <= ResetBackoffMode;
      cfg.retry_interval <= ResetInterval;
      cfg.ping_interval  <= ResetInterval;
      cfg.max_tries_main <= ResetTriesMain;
      cfg.max_tries_link <= ResetTriesLink;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BACKOFF_MODE:   cfg.backoff_mode   <= cfg_data[ModeW-1:0];
        CFG_RETRY_INTERVAL: cfg.retry_interval <= cfg_data[IntervalW-1:0];
        CFG_PING_INTERVAL:  cfg.ping_interval  <= cfg_data[IntervalW-1:0];
        CFG_MAX_TRIES_MAIN: cfg.max_tries_main <= cfg_data[LimitW-1:0];
        CFG_MAX_TRIES_LINK: cfg.max_tries_link <= cfg_data[LimitW-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item <= in_item_t'(s_axis_tdata[3:0]);
    end
  end

  cbrs_step u_step (
    .state      (state),
    .cfg        (cfg),
    .item       (in_item),
    .state_next (state_next),
    .result     (result)
  );

  // state commits as the item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OutDataW - OutUsedW)'(0), out_item};

endmodule

/* hdl/cbrs_step.sv */
// one tick of the stage sequencer: state, config and item in, next state and result out
`timescale 1ns / 1ps

module cbrs_step (
  input  cbrs_pkg::seq_state_t state,
  input  cbrs_pkg::cfg_t       cfg,
  input  cbrs_pkg::in_item_t   item,
  output cbrs_pkg::seq_state_t state_next,
  output cbrs_pkg::out_item_t  result
);
  import cbrs_pkg::*;

  stage_row_t        row;
  logic [TriesW-1:0] tries_inc;
  logic [LimitW-1:0] limit;
  logic [IntervalW-1:0] base;
  logic [ProdW-1:0]  square;
  logic [ProdW-1:0]  backoff;
  logic [ProdW-1:0]  reload_sum;
  logic              set_flag;
  logic              att;
  logic [StageW-1:0] att_stage;
  logic              ping;

  assign row       = stage_row(state.stage);
  assign tries_inc = state.tries + TriesW'(1);
  assign limit     = row.link_limit ? cfg.max_tries_link : cfg.max_tries_main;
  assign base      = row.ping_timing ? cfg.ping_interval : cfg.retry_interval;
  assign square    = ProdW'(tries_inc) * ProdW'(tries_inc);

  always_comb begin
    case (cfg.backoff_mode)
      BACKOFF_LINEAR: backoff = ProdW'(tries_inc) * ProdW'(BackoffStep);
      BACKOFF_QUAD:   backoff = square * ProdW'(BackoffStep);
      default:        backoff = '0;
    endcase
  end

  assign reload_sum = ProdW'(base) + backoff;

  always_comb begin
    state_next = state;
    set_flag   = 1'b0;
    att        = 1'b0;
    att_stage  = '0;
    ping       = 1'b0;
    if (!item.hold) begin
      if (state.stage != 3'd7) begin
        if (!item.ready_req) begin
          if (state.cooldown == '0) begin
            att                 = 1'b1;
            att_stage           = state.stage;
            state_next.tries    = tries_inc;
            state_next.cooldown = reload_sum[CoolW-1:0];
            // limit exceeded: drop to fail stage, counters cleared
            if (tries_inc > TriesW'(limit)) begin
              ping                = row.ping_timing;
              state_next.stage    = row.fail;
              state_next.tries    = '0;
              state_next.cooldown = '0;
              set_flag            = 1'b1;
            end
          end else begin
            state_next.cooldown = state.cooldown - CoolW'(1);
          end
        end else begin
          state_next.stage    = row.next;
          state_next.tries    = '0;
          state_next.cooldown = '0;
          set_flag            = 1'b1;
        end
      end
      case (item.opcode)
        OP_RELOAD: begin
          state_next.stage = StageNoConfig;
          ping             = 1'b1;
        end
        OP_INVALIDATE: begin
          state_next.stage    = StageNoConfig;
          state_next.tries    = '0;
          state_next.cooldown = '0;
          set_flag            = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    result.stage           = state_next.stage;
    result.stage_set       = set_flag;
    result.attempt         = att;
    result.attempt_stage   = att_stage;
    result.ping_invalidate = ping;
    result.try_count       = state_next.tries;
    result.cooldown_left   = state_next.cooldown;
  end

endmodule
